[sv/lpc_pkg.sv]
`timescale 1ns / 1ps

package lpc_pkg;

    // default geometry
    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF     = 32;

    // fixed field widths of the stream ports
    localparam int IN_DATA_W  = 32;
    localparam int SLOT_W     = 4;
    localparam int EV_PAGE_W  = 32;
    localparam int CNT_W      = 32;
    localparam int OUT_FLD_W  = 1 + SLOT_W + 1 + EV_PAGE_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // broadcast update command to every cell
    typedef struct packed {
        logic upd;
        logic hit;
    } cell_ctrl_t;

    // per-cell lookup status
    typedef struct packed {
        logic match;
        logic lru;
        logic valid;
    } cell_stat_t;

endpackage

[sv/lpc_cell.sv]
`timescale 1ns / 1ps

module lpc_cell #(
    parameter int CACHE_ENTRIES = lpc_pkg::CACHE_ENTRIES_DEF,
    parameter int PAGE_BITS     = lpc_pkg::PAGE_BITS_DEF,
    parameter int CELL_IDX      = 0,
    localparam int IDX_W        = $clog2(CACHE_ENTRIES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [PAGE_BITS-1:0]   req_page,
    input  lpc_pkg::cell_ctrl_t    ctrl,
    input  logic                   sel,
    input  logic [IDX_W-1:0]       sel_rank,
    output lpc_pkg::cell_stat_t    stat,
    output logic [PAGE_BITS-1:0]   page,
    output logic [IDX_W-1:0]       rank
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [IDX_W-1:0]     rank_reg;

    // tag compare and lru flag
    always_comb begin
        stat.match = valid_reg && (page_reg == req_page);
        stat.lru   = (rank_reg == '0);
        stat.valid = valid_reg;
    end

    assign page = page_reg;
    assign rank = rank_reg;

    // recency and validity update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= IDX_W'(CELL_IDX);
        end else if (ctrl.upd) begin
            if (sel) begin
                rank_reg <= IDX_W'(CACHE_ENTRIES - 1);
                if (!ctrl.hit) begin
                    valid_reg <= 1'b1;
                end
            end else if (rank_reg > sel_rank) begin
                rank_reg <= rank_reg - IDX_W'(1);
            end
        end
    end

    // tag write on fill
    always_ff @(posedge aclk) begin
        if (ctrl.upd && sel && !ctrl.hit) begin
            page_reg <= req_page;
        end
    end

endmodule

[sv/lru_page_cache_tags_top.sv]
`timescale 1ns / 1ps
// flow: a request is accepted in idle, then runs lookup and update over the row
//   of tag cells, which must finish before the next request is accepted; update
//   waits while the previous result is still held and not taken
// reset: synchronous, active low; clears all valid bits, sets rank order to slot
//   index order and the miss count to zero, with no clearing pass

module lru_page_cache_tags_top #(
    parameter int CACHE_ENTRIES = lpc_pkg::CACHE_ENTRIES_DEF,
    parameter int PAGE_BITS     = lpc_pkg::PAGE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpc_pkg::IN_DATA_W-1:0]   s_tdata,  // [31:0] page_number
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] hit, [4:1] slot, [5] evicted_valid, [37:6] evicted_page,
    // [69:38] miss_total, [71:70] zero
    output logic [lpc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [PAGE_BITS-1:0]          req_page_reg;
    logic [CACHE_ENTRIES-1:0]      sel_reg, sel_next;
    logic                          hit_reg, hit_next;
    logic [IDX_W-1:0]              sel_idx_reg, sel_idx_next;
    logic [IDX_W-1:0]              sel_rank_reg, sel_rank_next;
    logic                          ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0]          ev_page_reg, ev_page_next;
    logic [lpc_pkg::CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic                          m_tvalid_reg;
    logic [lpc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    lpc_pkg::cell_stat_t           stat [CACHE_ENTRIES];
    logic [PAGE_BITS-1:0]          cell_page [CACHE_ENTRIES];
    logic [IDX_W-1:0]              cell_rank [CACHE_ENTRIES];
    lpc_pkg::cell_ctrl_t           ctrl;
    logic                          out_free;
    logic                          s_fire;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign ctrl.upd = (state_reg == ST_UPD) && out_free;
    assign ctrl.hit = hit_reg;

    // row of tag cells
    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        lpc_cell #(
            .CACHE_ENTRIES (CACHE_ENTRIES),
            .PAGE_BITS     (PAGE_BITS),
            .CELL_IDX      (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req_page (req_page_reg),
            .ctrl     (ctrl),
            .sel      (sel_reg[g]),
            .sel_rank (sel_rank_reg),
            .stat     (stat[g]),
            .page     (cell_page[g]),
            .rank     (cell_rank[g])
        );
    end

    // pick the matching cell, else the lru cell; selection is one-hot
    always_comb begin
        logic any_hit;
        any_hit = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            any_hit = any_hit | stat[i].match;
        end
        hit_next      = any_hit;
        sel_idx_next  = '0;
        sel_rank_next = '0;
        ev_valid_next = 1'b0;
        ev_page_next  = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            sel_next[i] = any_hit ? stat[i].match : stat[i].lru;
            if (sel_next[i]) begin
                sel_idx_next  = sel_idx_next | IDX_W'(i);
                sel_rank_next = sel_rank_next | cell_rank[i];
                ev_valid_next = ev_valid_next | (!any_hit && stat[i].valid);
                if (!any_hit && stat[i].valid) begin
                    ev_page_next = ev_page_next | cell_page[i];
                end
            end
        end
    end

    // saturating miss count
    always_comb begin
        if (hit_reg || (miss_cnt_reg == '1)) begin
            miss_cnt_next = miss_cnt_reg;
        end else begin
            miss_cnt_next = miss_cnt_reg + lpc_pkg::CNT_W'(1);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            miss_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.upd) begin
                miss_cnt_reg <= miss_cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and lookup payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_page_reg <= PAGE_BITS'(s_tdata);
        end
        if (state_reg == ST_LOOK) begin
            sel_reg      <= sel_next;
            hit_reg      <= hit_next;
            sel_idx_reg  <= sel_idx_next;
            sel_rank_reg <= sel_rank_next;
            ev_valid_reg <= ev_valid_next;
            ev_page_reg  <= ev_page_next;
        end
        if (ctrl.upd) begin
            m_tdata_reg <= {2'b00,
                            miss_cnt_next,
                            lpc_pkg::EV_PAGE_W'(ev_page_reg),
                            ev_valid_reg,
                            lpc_pkg::SLOT_W'(sel_idx_reg),
                            hit_reg};
        end
    end

    // selection reaching the cells picks exactly one slot
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot(sel_reg))
        else $error("cell selection not one-hot");

    // an accepted request always goes to lookup
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_LOOK))
        else $error("accepted request did not start lookup");

    // miss count never decreases
    a_cnt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (miss_cnt_reg >= $past(miss_cnt_reg)))
        else $error("miss count decreased");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[0]) |-> !m_tdata_reg[5])
        else $error("eviction reported on hit");

    // no new request while a lookup is in flight
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request accepted during lookup");

endmodule

[tb/tb_lru_page_cache_tags_top.sv]
`timescale 1ns / 1ps

module tb_lru_page_cache_tags_top;

    localparam int NUM_SLOTS = lpc_pkg::CACHE_ENTRIES_DEF;
    localparam int POOL_MAX  = 24;
    localparam int EXP_DEPTH = 64;

    // one lookup result, hit in the lowest bit as on m_tdata
    typedef struct packed {
        logic [lpc_pkg::CNT_W-1:0]     miss_total;
        logic [lpc_pkg::EV_PAGE_W-1:0] evicted_page;
        logic                          evicted_valid;
        logic [lpc_pkg::SLOT_W-1:0]    slot;
        logic                          hit;
    } lookup_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lpc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // [31:0] page_number
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [0] hit, [4:1] slot, [5] evicted_valid, [37:6] evicted_page,
    // [69:38] miss_total, [71:70] zero
    logic [lpc_pkg::OUT_DATA_W-1:0] m_tdata;

    // shadow copy of the tag store
    logic [31:0]    cached_page [NUM_SLOTS];
    logic           cached_valid[NUM_SLOTS];
    int             age_rank    [NUM_SLOTS];
    logic [31:0]    miss_tally;

    // expected results in request order
    lookup_result_t expect_fifo[EXP_DEPTH];
    int             exp_wr    = 0;
    int             exp_rd    = 0;
    int             exp_count = 0;

    // hot page pool for lookups with reuse
    logic [31:0] hot_pages[POOL_MAX];
    int          pool_size = 8;

    bit idle_en       = 1'b0;
    int rx_hold_left  = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int evicts_seen   = 0;
    int requests_sent = 0;

    lru_page_cache_tags_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    // clear shadow state as reset does
    task automatic clear_cache_model();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cached_page[i]  = '0;
            cached_valid[i] = 1'b0;
            age_rank[i]     = i;
        end
        miss_tally = '0;
    endtask

    // lookup, fill on miss, then move the slot to most recent
    function automatic lookup_result_t predict_lookup(input logic [31:0] page);
        lookup_result_t r;
        int             s;
        bit             found;
        int             old_rank;
        r     = '0;
        s     = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && cached_valid[i] && cached_page[i] == page) begin
                found = 1'b1;
                s     = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
        end else begin
            // the rank-0 slot is free while any slot is free
            for (int i = 0; i < NUM_SLOTS; i++)
                if (age_rank[i] == 0) s = i;
            if (cached_valid[s]) begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = cached_page[s];
            end
            cached_page[s]  = page;
            cached_valid[s] = 1'b1;
            if (miss_tally != 32'hFFFF_FFFF) miss_tally = miss_tally + 32'd1;
        end
        old_rank = age_rank[s];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (age_rank[i] > old_rank) age_rank[i] = age_rank[i] - 1;
        age_rank[s]  = NUM_SLOTS - 1;
        r.slot       = s[lpc_pkg::SLOT_W-1:0];
        r.miss_total = miss_tally;
        return r;
    endfunction

    // drive one request and wait for its handshake
    task automatic send_page(input logic [31:0] page);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = page;
        do @(posedge aclk); while (!s_tready);
        expect_fifo[exp_wr] = predict_lookup(page);
        exp_wr    = (exp_wr + 1) % EXP_DEPTH;
        exp_count = exp_count + 1;
        requests_sent++;
    endtask

    // sender pause until every result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (exp_count == 0);
    endtask

    // mostly reuse of the pool, some fresh pool entries, some noise
    function automatic logic [31:0] pick_page();
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        idx  = $urandom_range(0, pool_size - 1);
        if (roll < 70) begin
            return hot_pages[idx];
        end else if (roll < 82) begin
            hot_pages[idx] = $urandom;
            return hot_pages[idx];
        end
        return $urandom;
    endfunction

    task automatic refill_pool();
        for (int i = 0; i < POOL_MAX; i++) hot_pages[i] = $urandom;
    endtask

    // result side: random stalls and long hold-offs
    initial begin
        int gap_left;
        gap_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready     = 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (gap_left > 0) begin
                m_tready = 1'b0;
                gap_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                gap_left = $urandom_range(1, 6) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(lookup_result_t)-1:0];
            results_seen++;
            if (exp_count == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0d slot=%0d ev=%0d evpage=%h misses=%0d",
                             got.hit, got.slot, got.evicted_valid, got.evicted_page,
                             got.miss_total);
            end else begin
                want      = expect_fifo[exp_rd];
                exp_rd    = (exp_rd + 1) % EXP_DEPTH;
                exp_count = exp_count - 1;
                if (want.hit) hits_seen++;
                if (want.evicted_valid) evicts_seen++;
                if (got.hit !== want.hit || got.slot !== want.slot ||
                    got.evicted_valid !== want.evicted_valid ||
                    got.evicted_page !== want.evicted_page ||
                    got.miss_total !== want.miss_total) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result %0d:", results_seen);
                        $display("  expected hit=%0d slot=%0d ev=%0d evpage=%h misses=%0d",
                                 want.hit, want.slot, want.evicted_valid,
                                 want.evicted_page, want.miss_total);
                        $display("  actual   hit=%0d slot=%0d ev=%0d evpage=%h misses=%0d",
                                 got.hit, got.slot, got.evicted_valid,
                                 got.evicted_page, got.miss_total);
                    end
                end
            end
        end
    end

    // extremes, fill from empty, eviction order, hits at both ends of the order
    task automatic test_directed();
        send_page(32'h0000_0000);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'hFFFF_FFFF);
        send_page(32'hAAAA_AAAA);
        send_page(32'h5555_5555);
        for (int i = 1; i <= 12; i++) send_page(i);
        // cache full: the oldest page goes
        send_page(32'h8000_0001);
        // hit in the middle of the order, then a miss
        send_page(32'h5555_5555);
        send_page(32'h7FFF_FFFE);
        // hit on the least recent page, then on the most recent
        send_page(32'hAAAA_AAAA);
        send_page(32'hAAAA_AAAA);
        send_page(32'h0000_0001);
        wait_drained();
    endtask

    // reuse-heavy traffic with pools of varying size around the slot count
    task automatic test_working_set();
        idle_en = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            refill_pool();
            pool_size = $urandom_range(4, POOL_MAX);
            for (int i = 0; i < 50; i++) send_page(pick_page());
        end
    endtask

    // long receiver hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        idle_en      = 1'b0;
        rx_hold_left = 120;
        for (int i = 0; i < 30; i++) send_page(pick_page());
        wait_drained();
        idle_en = 1'b1;
    endtask

    // random pages of full width mixed with reuse
    task automatic test_random_mix();
        pool_size = 17;
        refill_pool();
        for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 3) == 0) send_page($urandom);
            else send_page(pick_page());
        end
    endtask

    // back to back with no idling on either side
    task automatic test_streaming();
        idle_en   = 1'b0;
        pool_size = 16;
        for (int i = 0; i < 100; i++) send_page(pick_page());
        wait_drained();
    endtask

    initial begin
        clear_cache_model();
        refill_pool();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_working_set();
        test_backpressure();
        test_random_mix();
        test_streaming();

        repeat (12) @(posedge aclk);
        $display("covered %0d lookups: %0d hits, %0d misses, %0d evictions",
                 requests_sent, hits_seen, miss_tally, evicts_seen);
        $display("with random stalls on both sides, a long result hold-off and drains");
        if (mismatches == 0 && exp_count == 0) begin
            $display("** lru_page_cache_tags_top: PASSED **");
        end else begin
            $display("** lru_page_cache_tags_top: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", exp_count);
        $display("** lru_page_cache_tags_top: FAILED **");
        $finish;
    end

endmodule

[lru_page_cache_tags_top.f]
sv/lpc_pkg.sv
sv/lpc_cell.sv
sv/lru_page_cache_tags_top.sv
tb/tb_lru_page_cache_tags_top.sv
